// ----- hdl/frame_fifo_replacement_core_defines.svh -----
// ----------------------------------------------------------------------------
// frame_fifo_replacement_core_defines: assertion macros
// Shared concurrent assertion shorthands for the frame allocator checkers.
// ----------------------------------------------------------------------------
`ifndef FRAME_FIFO_REPLACEMENT_CORE_DEFINES_SVH
`define FRAME_FIFO_REPLACEMENT_CORE_DEFINES_SVH

// same-cycle implication
`define FFR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FFR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/ffr_pkg.sv -----
// ----------------------------------------------------------------------------
// ffr_pkg: frame allocator types and constants
// Transaction payloads, cell control group, state codes and defaults.
// ----------------------------------------------------------------------------
package ffr_pkg;

   localparam int FRAMES_DEFAULT     = 32;
   localparam int SWAP_SLOTS_DEFAULT = 64;
   localparam int AGE_WIDTH_DEFAULT  = 16;

   localparam int OWNER_WIDTH = 32;

   localparam logic KIND_ALLOC = 1'b0;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_NO_SWAP    = 2'd1;
   localparam logic [1:0] STATUS_ALL_PINNED = 2'd2;

   typedef struct packed {
      logic                   kind;
      logic                   pin_request;
      logic [OWNER_WIDTH-1:0] owner_tag;
      logic [5:0]             release_slot;
   } req_type;

   typedef struct packed {
      logic [4:0]             frame_index;
      logic                   evicted;
      logic [OWNER_WIDTH-1:0] evicted_owner;
      logic [5:0]             swap_slot;
      logic [1:0]             status;
      logic [5:0]             fresh_frames;
      logic [5:0]             pin_total;
      logic [6:0]             swap_used;
   } rsp_type;

   typedef struct packed {
      logic shift;
      logic take;
      logic pin;
   } cell_ctrl_type;

   typedef struct packed {
      logic used;
      logic pinned;
   } frame_flags_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_COMMIT = 3'b100
   } state_type;

endpackage

// ----- hdl/ffr_frame_cell.sv -----
// ----------------------------------------------------------------------------
// ffr_frame_cell: one physical frame entry of the rotating frame ring
// Holds used/pinned flags, age and owner tag; shifts from its neighbor or
// takes a new allocation.
// ----------------------------------------------------------------------------
module ffr_frame_cell #(
   parameter int AGE_WIDTH = ffr_pkg::AGE_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ffr_pkg::cell_ctrl_type            ctrl,
   input  ffr_pkg::frame_flags_type          nbr_flags,
   input  logic [AGE_WIDTH-1:0]              nbr_age,
   input  logic [ffr_pkg::OWNER_WIDTH-1:0]   nbr_owner,
   input  logic [ffr_pkg::OWNER_WIDTH-1:0]   wr_owner,
   output ffr_pkg::frame_flags_type          flags,
   output logic [AGE_WIDTH-1:0]              age,
   output logic [ffr_pkg::OWNER_WIDTH-1:0]   owner
);

   ffr_pkg::frame_flags_type        flags_ff;
   logic [AGE_WIDTH-1:0]            age_ff;
   logic [ffr_pkg::OWNER_WIDTH-1:0] owner_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
         age_ff   <= '0;
      end else if (ctrl.take) begin
         flags_ff <= '{used: 1'b1, pinned: ctrl.pin};
         age_ff   <= '0;
      end else if (ctrl.shift) begin
         flags_ff <= nbr_flags;
         age_ff   <= nbr_age;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.take) begin
         owner_ff <= wr_owner;
      end else if (ctrl.shift) begin
         owner_ff <= nbr_owner;
      end
   end

   assign flags = flags_ff;
   assign age   = age_ff;
   assign owner = owner_ff;

endmodule

// ----- hdl/ffr_slot_cell.sv -----
// ----------------------------------------------------------------------------
// ffr_slot_cell: one swap slot of the rotating slot ring
// Holds the slot's used bit; shifts from its neighbor or is marked used.
// ----------------------------------------------------------------------------
module ffr_slot_cell (
   input  logic clock,
   input  logic reset,
   input  logic shift,
   input  logic set,
   input  logic nbr,
   output logic used
);

   logic used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else if (set) begin
         used_ff <= 1'b1;
      end else if (shift) begin
         used_ff <= nbr;
      end
   end

   assign used = used_ff;

endmodule

// ----- hdl/frame_fifo_replacement_core.sv -----
// ----------------------------------------------------------------------------
// frame_fifo_replacement_core: frame allocator with FIFO-age eviction and pinning
// A request is taken in ST_IDLE and walks the frame and swap-slot rings in ST_SCAN; ST_COMMIT
// registers the response unless a held one is stalled; req_stall blocks requests outside ST_IDLE.
// Reset: synchronous; clears frame flags, ages, swap slots and counters; owner tags stay.
// ----------------------------------------------------------------------------
module frame_fifo_replacement_core #(
   parameter int FRAMES     = ffr_pkg::FRAMES_DEFAULT,
   parameter int SWAP_SLOTS = ffr_pkg::SWAP_SLOTS_DEFAULT,
   parameter int AGE_WIDTH  = ffr_pkg::AGE_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ffr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ffr_pkg::rsp_type rsp_data
);

   localparam int FW       = $clog2(FRAMES);
   localparam int SW       = (SWAP_SLOTS > 1) ? $clog2(SWAP_SLOTS) : 1;
   localparam int SCAN_LEN = (FRAMES > SWAP_SLOTS) ? FRAMES : SWAP_SLOTS;
   localparam int LW       = $clog2(SCAN_LEN);
   localparam int FCW      = $clog2(FRAMES + 1);
   localparam int SCW      = $clog2(SWAP_SLOTS + 1);
   localparam int CMPW     = (SW > 6) ? SW : 6;
   localparam logic [AGE_WIDTH-1:0] AGE_MAX = {AGE_WIDTH{1'b1}};

   ffr_pkg::state_type state_ff, state_in;
   ffr_pkg::req_type   req_ff;
   ffr_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff;

   logic [LW-1:0]        step_ff, step_in;
   logic                 found_ff, found_in;
   logic [FW-1:0]        fidx_ff, fidx_in;
   logic [AGE_WIDTH-1:0] best_ff, best_in;
   logic [FW-1:0]        victim_ff, victim_in;
   logic [ffr_pkg::OWNER_WIDTH-1:0] vowner_ff, vowner_in;
   logic                 have_ff, have_in;
   logic [SW-1:0]        sidx_ff, sidx_in;
   logic                 rel_hit_ff, rel_hit_in;

   logic [FCW-1:0] free_cnt_ff, free_cnt_in;
   logic [FCW-1:0] pinned_cnt_ff, pinned_cnt_in;
   logic [SCW-1:0] swap_cnt_ff, swap_cnt_in;

   ffr_pkg::frame_flags_type        cell_flags [FRAMES];
   logic [AGE_WIDTH-1:0]            cell_age   [FRAMES];
   logic [ffr_pkg::OWNER_WIDTH-1:0] cell_owner [FRAMES];
   ffr_pkg::cell_ctrl_type          frame_ctrl [FRAMES];
   logic                            slot_q     [SWAP_SLOTS];

   logic                 accept;
   logic                 do_commit;
   logic                 is_alloc;
   logic                 frame_shift;
   logic                 slot_shift;
   logic                 scanning;
   logic [FW-1:0]        frame_t;
   logic [SW-1:0]        slot_t;
   logic [AGE_WIDTH-1:0] head_age_new;
   logic                 head_slot_new;
   logic                 slot_look;
   logic                 slot_release;
   logic                 take_en;
   logic [FW-1:0]        take_idx;
   logic                 slot_set;

   assign accept      = req_valid && (state_ff == ffr_pkg::ST_IDLE);
   assign req_stall   = (state_ff != ffr_pkg::ST_IDLE);
   assign do_commit   = (state_ff == ffr_pkg::ST_COMMIT) && (!rsp_valid_ff || !rsp_stall);
   assign is_alloc    = (req_ff.kind == ffr_pkg::KIND_ALLOC);
   assign frame_t     = step_ff[FW-1:0];
   assign slot_t      = step_ff[SW-1:0];
   assign frame_shift = (state_ff == ffr_pkg::ST_SCAN) &&
                        ({1'b0, step_ff} < (LW+1)'(FRAMES));
   assign slot_shift  = (state_ff == ffr_pkg::ST_SCAN) &&
                        ({1'b0, step_ff} < (LW+1)'(SWAP_SLOTS));
   assign scanning    = frame_shift && is_alloc && !found_ff;

   // head of frame ring: age used, unpinned frames passed before the first free one
   assign head_age_new = (scanning && cell_flags[0].used && !cell_flags[0].pinned &&
                          (cell_age[0] != AGE_MAX)) ? cell_age[0] + AGE_WIDTH'(1)
                                                    : cell_age[0];

   assign slot_look     = slot_shift && is_alloc && !have_ff && !slot_q[0];
   assign slot_release  = slot_shift && !is_alloc && slot_q[0] &&
                          (CMPW'(req_ff.release_slot) == CMPW'(slot_t));
   assign head_slot_new = slot_release ? 1'b0 : slot_q[0];

   genvar k;
   generate
      for (k = 0; k < FRAMES; k++) begin : g_frame
         assign frame_ctrl[k] = '{shift: frame_shift,
                                  take:  take_en && (take_idx == FW'(k)),
                                  pin:   req_ff.pin_request};
         if (k == FRAMES - 1) begin : g_tail
            ffr_frame_cell #(.AGE_WIDTH(AGE_WIDTH)) u_cell (
               .clock     (clock),
               .reset     (reset),
               .ctrl      (frame_ctrl[k]),
               .nbr_flags (cell_flags[0]),
               .nbr_age   (head_age_new),
               .nbr_owner (cell_owner[0]),
               .wr_owner  (req_ff.owner_tag),
               .flags     (cell_flags[k]),
               .age       (cell_age[k]),
               .owner     (cell_owner[k])
            );
         end else begin : g_body
            ffr_frame_cell #(.AGE_WIDTH(AGE_WIDTH)) u_cell (
               .clock     (clock),
               .reset     (reset),
               .ctrl      (frame_ctrl[k]),
               .nbr_flags (cell_flags[k+1]),
               .nbr_age   (cell_age[k+1]),
               .nbr_owner (cell_owner[k+1]),
               .wr_owner  (req_ff.owner_tag),
               .flags     (cell_flags[k]),
               .age       (cell_age[k]),
               .owner     (cell_owner[k])
            );
         end
      end

      for (k = 0; k < SWAP_SLOTS; k++) begin : g_slot
         if (k == SWAP_SLOTS - 1) begin : g_tail
            ffr_slot_cell u_cell (
               .clock (clock),
               .reset (reset),
               .shift (slot_shift),
               .set   (slot_set && (sidx_ff == SW'(k))),
               .nbr   (head_slot_new),
               .used  (slot_q[k])
            );
         end else begin : g_body
            ffr_slot_cell u_cell (
               .clock (clock),
               .reset (reset),
               .shift (slot_shift),
               .set   (slot_set && (sidx_ff == SW'(k))),
               .nbr   (slot_q[k+1]),
               .used  (slot_q[k])
            );
         end
      end
   endgenerate

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffr_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = ffr_pkg::ST_SCAN;
            end
         end
         ffr_pkg::ST_SCAN: begin
            if (step_ff == LW'(SCAN_LEN - 1)) begin
               state_in = ffr_pkg::ST_COMMIT;
            end
         end
         ffr_pkg::ST_COMMIT: begin
            if (do_commit) begin
               state_in = ffr_pkg::ST_IDLE;
            end
         end
         default: state_in = ffr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      step_in    = step_ff;
      found_in   = found_ff;
      fidx_in    = fidx_ff;
      best_in    = best_ff;
      victim_in  = victim_ff;
      vowner_in  = vowner_ff;
      have_in    = have_ff;
      sidx_in    = sidx_ff;
      rel_hit_in = rel_hit_ff;
      if (accept) begin
         step_in    = '0;
         found_in   = 1'b0;
         best_in    = '0;
         have_in    = 1'b0;
         rel_hit_in = 1'b0;
      end else if (state_ff == ffr_pkg::ST_SCAN) begin
         step_in = step_ff + LW'(1);
         if (scanning) begin
            if (!cell_flags[0].used) begin
               found_in = 1'b1;
               fidx_in  = frame_t;
            end else if (head_age_new > best_ff) begin
               best_in   = head_age_new;
               victim_in = frame_t;
               vowner_in = cell_owner[0];
            end
         end
         if (slot_look) begin
            have_in = 1'b1;
            sidx_in = slot_t;
         end
         if (slot_release) begin
            rel_hit_in = 1'b1;
         end
      end
   end

   always_comb begin
      logic take_raw;
      logic set_raw;
      logic pin_inc;
      take_raw      = 1'b0;
      set_raw       = 1'b0;
      pin_inc       = 1'b0;
      take_idx      = fidx_ff;
      free_cnt_in   = free_cnt_ff;
      pinned_cnt_in = pinned_cnt_ff;
      swap_cnt_in   = swap_cnt_ff;
      rsp_in        = '0;
      rsp_in.status = ffr_pkg::STATUS_OK;
      if (is_alloc) begin
         if (found_ff) begin
            take_raw = 1'b1;
            pin_inc  = req_ff.pin_request;
            if (free_cnt_ff != '0) begin
               free_cnt_in = free_cnt_ff - FCW'(1);
            end
            rsp_in.frame_index = 5'(fidx_ff);
         end else if (best_ff == '0) begin
            rsp_in.status = ffr_pkg::STATUS_ALL_PINNED;
         end else if (!have_ff) begin
            rsp_in.status = ffr_pkg::STATUS_NO_SWAP;
         end else begin
            take_raw = 1'b1;
            set_raw  = 1'b1;
            pin_inc  = req_ff.pin_request;
            take_idx = victim_ff;
            if (swap_cnt_ff < SCW'(SWAP_SLOTS)) begin
               swap_cnt_in = swap_cnt_ff + SCW'(1);
            end
            rsp_in.frame_index   = 5'(victim_ff);
            rsp_in.evicted       = 1'b1;
            rsp_in.evicted_owner = vowner_ff;
            rsp_in.swap_slot     = 6'(sidx_ff);
         end
      end else if (rel_hit_ff && (swap_cnt_ff != '0)) begin
         swap_cnt_in = swap_cnt_ff - SCW'(1);
      end
      if (pin_inc && (pinned_cnt_ff < FCW'(FRAMES))) begin
         pinned_cnt_in = pinned_cnt_ff + FCW'(1);
      end
      rsp_in.fresh_frames = 6'(free_cnt_in);
      rsp_in.pin_total    = 6'(pinned_cnt_in);
      rsp_in.swap_used    = 7'(swap_cnt_in);
      take_en  = do_commit && take_raw;
      slot_set = do_commit && set_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ffr_pkg::ST_IDLE;
         step_ff       <= '0;
         found_ff      <= 1'b0;
         best_ff       <= '0;
         have_ff       <= 1'b0;
         rel_hit_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         free_cnt_ff   <= FCW'(FRAMES);
         pinned_cnt_ff <= '0;
         swap_cnt_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         step_ff    <= step_in;
         found_ff   <= found_in;
         best_ff    <= best_in;
         have_ff    <= have_in;
         rel_hit_ff <= rel_hit_in;
         if (do_commit) begin
            rsp_valid_ff  <= 1'b1;
            free_cnt_ff   <= free_cnt_in;
            pinned_cnt_ff <= pinned_cnt_in;
            swap_cnt_ff   <= swap_cnt_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (do_commit) begin
         rsp_ff <= rsp_in;
      end
      fidx_ff   <= fidx_in;
      victim_ff <= victim_in;
      vowner_ff <= vowner_in;
      sidx_ff   <= sidx_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hdl/ffr_checker.sv -----
// ----------------------------------------------------------------------------
// ffr_checker: port-level checks for the frame allocator
// Request serialization, response handshake and result consistency, bound to the top level.
// ----------------------------------------------------------------------------
`include "frame_fifo_replacement_core_defines.svh"

module ffr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ffr_pkg::rsp_type rsp_data
);

   logic req_accept;

   assign req_accept = req_valid && !req_stall;

   `FFR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid,
                   "rsp_valid dropped while stalled")
   `FFR_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data),
                   "rsp_data changed while stalled")
   `FFR_ASSERT_NXT(a_one_at_a_time, clock, reset, req_accept, req_stall,
                   "second transaction taken during a walk")
   `FFR_ASSERT_IMP(a_evict_ok, clock, reset, rsp_valid && rsp_data.evicted,
                   rsp_data.status == ffr_pkg::STATUS_OK,
                   "eviction reported with failure status")
   `FFR_ASSERT_IMP(a_fail_clean, clock, reset,
                   rsp_valid && (rsp_data.status != ffr_pkg::STATUS_OK),
                   !rsp_data.evicted && (rsp_data.frame_index == 5'd0),
                   "failed allocate carries a frame")

endmodule

bind frame_fifo_replacement_core ffr_checker u_ffr_checker (.*);

// ----- sim/frame_fifo_replacement_core_test.sv -----
// ----------------------------------------------------------------------------
// frame_fifo_replacement_core_test: self-checking bench for the frame allocator
// Runs a short directed table, then several phases of random allocate and
// release traffic that fill the frames, exhaust and drain swap, and pin every
// frame. Each response is checked field by field against a behavioral predictor
// or the directed table. Random idling is applied on both the request and response sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module frame_fifo_replacement_core_test;

   localparam int          FRAMES      = ffr_pkg::FRAMES_DEFAULT;
   localparam int          SWAP_SLOTS  = ffr_pkg::SWAP_SLOTS_DEFAULT;
   localparam int          AGE_WIDTH   = ffr_pkg::AGE_WIDTH_DEFAULT;
   localparam int unsigned AGE_LIMIT   = (1 << AGE_WIDTH) - 1;
   localparam logic        KIND_FREE   = 1'b1;
   localparam int          CYCLE_LIMIT = 250000;
   localparam int          SETTLE      = 100;

   typedef enum {MIX_CHURN, MIX_SWAP_FULL, MIX_DRAIN, MIX_PIN_ALL} mix_type;

   typedef struct {
      ffr_pkg::req_type rq;
      bit               typed;
      ffr_pkg::rsp_type want;
   } directed_row_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   ffr_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   ffr_pkg::rsp_type rsp_data;

   // predictor state
   logic        fr_used   [FRAMES];
   logic        fr_pinned [FRAMES];
   int unsigned fr_age    [FRAMES];
   logic [31:0] fr_owner  [FRAMES];
   logic        slot_busy [SWAP_SLOTS];
   int unsigned n_free;
   int unsigned n_pinned;
   int unsigned n_swap;

   ffr_pkg::rsp_type pending_grants [$];
   directed_row_type directed_rows  [$];

   int error_count   = 0;
   int rsp_count     = 0;
   int cycle_count   = 0;
   int allocations   = 0;
   int releases      = 0;
   int evictions     = 0;
   int refused_swap  = 0;
   int refused_pin   = 0;
   bit calm          = 1'b0;

   frame_fifo_replacement_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
               pending_grants.size());
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic void occupy_frame(input int f, input logic pin, input logic [31:0] owner);
      fr_used[f]   = 1'b1;
      fr_pinned[f] = pin;
      fr_age[f]    = 0;
      fr_owner[f]  = owner;
      if (pin && n_pinned < FRAMES) n_pinned++;
   endfunction

   function automatic ffr_pkg::rsp_type compute_allocation(input ffr_pkg::req_type rq);
      ffr_pkg::rsp_type r;
      int               f;
      int               s;
      int               victim;
      int unsigned      oldest;
      bit               found;
      r      = '0;
      victim = 0;
      oldest = 0;
      found  = 1'b0;
      if (rq.kind == ffr_pkg::KIND_ALLOC) begin
         allocations++;
         for (f = 0; f < FRAMES; f++) begin
            if (!fr_used[f]) begin
               found = 1'b1;
               break;
            end
            if (!fr_pinned[f] && fr_age[f] < AGE_LIMIT) fr_age[f]++;
            if (fr_age[f] > oldest) begin
               oldest = fr_age[f];
               victim = f;
            end
         end
         if (found) begin
            occupy_frame(f, rq.pin_request, rq.owner_tag);
            if (n_free > 0) n_free--;
            r.frame_index = 5'(f);
         end else if (oldest == 0) begin
            r.status = ffr_pkg::STATUS_ALL_PINNED;
            refused_pin++;
         end else begin
            for (s = 0; s < SWAP_SLOTS; s++) begin
               if (!slot_busy[s]) break;
            end
            if (s == SWAP_SLOTS) begin
               r.status = ffr_pkg::STATUS_NO_SWAP;
               refused_swap++;
            end else begin
               slot_busy[s] = 1'b1;
               if (n_swap < SWAP_SLOTS) n_swap++;
               r.evicted       = 1'b1;
               r.evicted_owner = fr_owner[victim];
               r.swap_slot     = 6'(s);
               r.frame_index   = 5'(victim);
               occupy_frame(victim, rq.pin_request, rq.owner_tag);
               evictions++;
            end
         end
      end else begin
         releases++;
         if (rq.release_slot < SWAP_SLOTS && slot_busy[rq.release_slot]) begin
            slot_busy[rq.release_slot] = 1'b0;
            if (n_swap > 0) n_swap--;
         end
      end
      r.fresh_frames = 6'(n_free);
      r.pin_total    = 6'(n_pinned);
      r.swap_used    = 7'(n_swap);
      return r;
   endfunction

   // well-formed traffic for each phase, with some stray releases as noise
   function automatic ffr_pkg::req_type draw_request(input mix_type mix);
      ffr_pkg::req_type rq;
      int               roll;
      bit               rel;
      int               busy [$];
      rq.kind         = ffr_pkg::KIND_ALLOC;
      rq.pin_request  = 1'b0;
      rq.owner_tag    = $urandom();
      rq.release_slot = 6'($urandom_range(0, 63));
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_CHURN:     rel = roll < 25;
         MIX_SWAP_FULL: rel = roll < 3;
         MIX_DRAIN:     rel = roll < 60;
         default:       rel = (n_swap == SWAP_SLOTS && n_pinned < FRAMES) || roll < 10;
      endcase
      if (rel) begin
         rq.kind = KIND_FREE;
         rq.pin_request = 1'($urandom_range(0, 1));
         foreach (slot_busy[i]) begin
            if (slot_busy[i]) busy.push_back(i);
         end
         if (busy.size() > 0 && $urandom_range(0, 9) < 8)
            rq.release_slot = 6'(busy[$urandom_range(0, busy.size() - 1)]);
      end else if (mix == MIX_PIN_ALL) begin
         rq.pin_request = ($urandom_range(0, 9) != 0);
      end else begin
         rq.pin_request = (n_pinned < 6) && ($urandom_range(0, 19) == 0);
      end
      return rq;
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      if (error_count <= 40)
         $display("mismatch in response %0d, %s: got 0x%0h, expected 0x%0h", rsp_count, field,
                  got, want);
   endtask

   task automatic issue(input ffr_pkg::req_type rq, input bit typed,
                        input ffr_pkg::rsp_type typed_want);
      ffr_pkg::rsp_type predicted;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = compute_allocation(rq);
      pending_grants.push_back(typed ? typed_want : predicted);
   endtask

   task automatic run_mix(input mix_type mix, input int count);
      int k;
      for (k = 0; k < count; k++) issue(draw_request(mix), 1'b0, '0);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_grants.size() != 0);
   endtask

   task automatic add_row(input logic kind, input logic pin, input logic [31:0] owner,
                          input logic [5:0] slot, input bit typed, input int frame,
                          input int free_n, input int pin_n);
      directed_row_type row;
      row.rq.kind               = kind;
      row.rq.pin_request        = pin;
      row.rq.owner_tag          = owner;
      row.rq.release_slot       = slot;
      row.typed                 = typed;
      row.want                  = '0;
      row.want.frame_index      = 5'(frame);
      row.want.status           = ffr_pkg::STATUS_OK;
      row.want.fresh_frames     = 6'(free_n);
      row.want.pin_total        = 6'(pin_n);
      directed_rows.push_back(row);
   endtask

   always @(posedge clock) begin : rsp_monitor
      ffr_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_grants.size() == 0) begin
            report_mismatch("unexpected transaction", 64'(rsp_data), 64'(0));
         end else begin
            want = pending_grants.pop_front();
            if (rsp_data.frame_index !== want.frame_index)
               report_mismatch("frame_index", 64'(rsp_data.frame_index),
                               64'(want.frame_index));
            if (rsp_data.evicted !== want.evicted)
               report_mismatch("evicted", 64'(rsp_data.evicted), 64'(want.evicted));
            if (rsp_data.evicted_owner !== want.evicted_owner)
               report_mismatch("evicted_owner", 64'(rsp_data.evicted_owner),
                               64'(want.evicted_owner));
            if (rsp_data.swap_slot !== want.swap_slot)
               report_mismatch("swap_slot", 64'(rsp_data.swap_slot), 64'(want.swap_slot));
            if (rsp_data.status !== want.status)
               report_mismatch("status", 64'(rsp_data.status), 64'(want.status));
            if (rsp_data.fresh_frames !== want.fresh_frames)
               report_mismatch("fresh_frames", 64'(rsp_data.fresh_frames),
                               64'(want.fresh_frames));
            if (rsp_data.pin_total !== want.pin_total)
               report_mismatch("pin_total", 64'(rsp_data.pin_total), 64'(want.pin_total));
            if (rsp_data.swap_used !== want.swap_used)
               report_mismatch("swap_used", 64'(rsp_data.swap_used), 64'(want.swap_used));
         end
         rsp_count++;
      end
   end

   initial begin : rsp_backpressure
      int n;
      do @(posedge clock); while (reset);
      forever begin
         if (calm) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            n = $urandom_range(1, 10);
            rsp_stall <= ($urandom_range(0, 2) == 0);
            repeat (n) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int k;
      foreach (fr_used[i]) begin
         fr_used[i]   = 1'b0;
         fr_pinned[i] = 1'b0;
         fr_age[i]    = 0;
         fr_owner[i]  = '0;
      end
      foreach (slot_busy[i]) slot_busy[i] = 1'b0;
      n_free   = FRAMES;
      n_pinned = 0;
      n_swap   = 0;

      // releases of free slots are no-ops; first allocations fill from frame 0
      add_row(KIND_FREE,          1'b0, 32'h0000_0000, 6'd0,  1'b1, 0, 32, 0);
      add_row(KIND_FREE,          1'b1, 32'hFFFF_FFFF, 6'd63, 1'b1, 0, 32, 0);
      add_row(ffr_pkg::KIND_ALLOC, 1'b0, 32'hFFFF_FFFF, 6'd63, 1'b1, 0, 31, 0);
      add_row(ffr_pkg::KIND_ALLOC, 1'b1, 32'h0000_0000, 6'd0,  1'b1, 1, 30, 1);
      add_row(ffr_pkg::KIND_ALLOC, 1'b0, 32'h8000_0001, 6'h2A, 1'b1, 2, 29, 1);
      add_row(ffr_pkg::KIND_ALLOC, 1'b1, 32'h7FFF_FFFE, 6'h15, 1'b1, 3, 28, 2);
      add_row(KIND_FREE,          1'b0, 32'h0000_0000, 6'd5,  1'b1, 0, 28, 2);
      add_row(ffr_pkg::KIND_ALLOC, 1'b0, 32'hA5A5_A5A5, 6'd0,  1'b0, 0, 0, 0);
      add_row(ffr_pkg::KIND_ALLOC, 1'b0, 32'h5A5A_5A5A, 6'd0,  1'b0, 0, 0, 0);
      add_row(KIND_FREE,          1'b0, 32'h0000_0000, 6'd31, 1'b0, 0, 0, 0);
      add_row(ffr_pkg::KIND_ALLOC, 1'b0, 32'h0000_FFFF, 6'd0,  1'b0, 0, 0, 0);
      add_row(ffr_pkg::KIND_ALLOC, 1'b0, 32'hFFFF_0000, 6'd0,  1'b0, 0, 0, 0);
      add_row(KIND_FREE,          1'b1, 32'h1234_5678, 6'd32, 1'b0, 0, 0, 0);
      add_row(ffr_pkg::KIND_ALLOC, 1'b0, 32'h1234_5678, 6'd1,  1'b0, 0, 0, 0);
      add_row(ffr_pkg::KIND_ALLOC, 1'b0, 32'hDEAD_BEEF, 6'd62, 1'b0, 0, 0, 0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < directed_rows.size(); k++)
         issue(directed_rows[k].rq, directed_rows[k].typed, directed_rows[k].want);
      drain_results();

      run_mix(MIX_CHURN, 60);
      calm = 1'b1;
      run_mix(MIX_CHURN, 40);
      calm = 1'b0;
      run_mix(MIX_CHURN, 80);
      drain_results();
      run_mix(MIX_SWAP_FULL, 60);
      drain_results();
      run_mix(MIX_DRAIN, 70);
      run_mix(MIX_PIN_ALL, 60);
      calm = 1'b1;
      run_mix(MIX_PIN_ALL, 40);

      req_valid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("covered %0d allocations and %0d releases over %0d responses", allocations,
               releases, rsp_count);
      $display("saw %0d evictions, %0d refusals for full swap, %0d for all frames pinned",
               evictions, refused_swap, refused_pin);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", error_count);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
